// ===== rtl/text_terminal_cell_buffer_macros.svh =====
// Assertion macros shared by the text terminal cell buffer checks
`ifndef TEXT_TERMINAL_CELL_BUFFER_MACROS_SVH
`define TEXT_TERMINAL_CELL_BUFFER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TTCB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text_terminal_cell_buffer: check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TTCB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("text_terminal_cell_buffer: check failed");

`endif

// ===== rtl/ttcb_pkg.sv =====
// Shared widths, codes and types of the text terminal cell buffer
`timescale 1ns / 1ps
package ttcb_pkg;

	localparam int ACT_W   = 4;
	localparam int ROW_W   = 4;
	localparam int COL_W   = 5;
	localparam int CHAR_W  = 8;
	localparam int DIR_W   = 2;
	localparam int DIRTY_W = 15;
	localparam int CELL_W  = 8;

	localparam int DEF_ROWS    = 15;
	localparam int DEF_COLUMNS = 25;

	localparam logic [CHAR_W-1:0] CODE_BIAS = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE   = 8'h0A;

	localparam logic [ACT_W-1:0] ACT_WRITE      = 4'd0;
	localparam logic [ACT_W-1:0] ACT_PUT        = 4'd1;
	localparam logic [ACT_W-1:0] ACT_GET        = 4'd2;
	localparam logic [ACT_W-1:0] ACT_INVERT     = 4'd3;
	localparam logic [ACT_W-1:0] ACT_SET_CURSOR = 4'd4;
	localparam logic [ACT_W-1:0] ACT_READ_CURSOR = 4'd5;
	localparam logic [ACT_W-1:0] ACT_SCROLL     = 4'd6;
	localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd7;
	localparam logic [ACT_W-1:0] ACT_TAKE_DIRTY = 4'd8;
	localparam logic [ACT_W-1:0] ACT_MARK_DIRTY = 4'd9;

	localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_DRAIN,
		ST_PUTW,
		ST_RESP
	} state_t;

	typedef enum logic [2:0] {
		SW_UP,
		SW_DOWN,
		SW_LEFT,
		SW_RIGHT,
		SW_INV_SET,
		SW_INV_CLR,
		SW_ZERO
	} sweep_t;

endpackage

// ===== rtl/text_terminal_cell_buffer.sv =====
// Cell, cursor and dirty actions pass ST_IDLE, ST_EXEC and ST_RESP; the result beat is registered.
// Scroll, clear and a terminal write that scrolls sweep the cell memory one cell a cycle;
// a printable write that scrolls stores its character after the sweep; invert sweeps one line.
// One item at a time: the next beat is taken in the cycle after the result loads.
// After arst_n the cell memory is cleared by a sweep pass, with in_stall high.
// Cursor, dirty mask and the stored text_inverse setting reset to zero.
`timescale 1ns / 1ps
module text_terminal_cell_buffer #(
	parameter int ROWS    = ttcb_pkg::DEF_ROWS,
	parameter int COLUMNS = ttcb_pkg::DEF_COLUMNS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic                          text_inverse,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ttcb_pkg::ACT_W-1:0]    action,
	input  logic [ttcb_pkg::ROW_W-1:0]    row,
	input  logic [ttcb_pkg::COL_W-1:0]    column,
	input  logic [ttcb_pkg::CHAR_W-1:0]   char_code,
	input  logic                          invert_flag,
	input  logic [ttcb_pkg::DIR_W-1:0]    direction,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ttcb_pkg::CHAR_W-1:0]   char_out,
	output logic [ttcb_pkg::ROW_W-1:0]    cursor_row_out,
	output logic [ttcb_pkg::COL_W-1:0]    cursor_column_out,
	output logic [ttcb_pkg::DIRTY_W-1:0]  dirty_out
);
	import ttcb_pkg::*;

	localparam int ROW_AW    = $clog2(ROWS);
	localparam int ADDR_W    = ROW_AW + COL_W;
	localparam int MEM_DEPTH = ROWS << COL_W;

	localparam logic [ROW_W-1:0]   ROWS_L   = ROW_W'(ROWS);
	localparam logic [ROW_W-1:0]   LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]   COLS_L   = COL_W'(COLUMNS);
	localparam logic [COL_W-1:0]   LAST_COL = COL_W'(COLUMNS - 1);
	localparam logic [DIRTY_W-1:0] ALL_ROWS = DIRTY_W'((1 << ROWS) - 1);

	function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return {r[ROW_AW-1:0], c};
	endfunction

	// cell memory: row in the upper address bits, column in the lower five
	logic [CELL_W-1:0] cell_mem_q [MEM_DEPTH];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] rd_data_s1;

	state_t state_q, state_d;

	logic               inverse_q;
	logic [ACT_W-1:0]   act_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [CHAR_W-1:0]  char_q;
	logic               inv_flag_q;
	logic [DIR_W-1:0]   dir_q;

	logic [ROW_W-1:0]   cursor_row_q, cursor_row_d;
	logic [COL_W-1:0]   cursor_col_q, cursor_col_d;
	logic [DIRTY_W-1:0] dirty_q, dirty_d;

	sweep_t             sw_mode_q, sw_mode_d;
	logic [ROW_W-1:0]   sw_row_q, sw_row_d;
	logic [COL_W-1:0]   sw_col_q, sw_col_d;
	logic               init_q, init_d;
	logic               post_put_q, post_put_d;
	logic [ADDR_W-1:0]  put_addr_q, put_addr_d;
	logic [CELL_W-1:0]  put_data_q, put_data_d;
	logic               get_hit_q, get_hit_d;

	// sweep write-back stage, writing in the cycle after the read
	logic               wr_en_s1, wr_en_d;
	logic [ADDR_W-1:0]  wr_addr_s1, wr_addr_d;
	logic               fill_s1, fill_d;
	sweep_t             sw_mode_s1;
	logic [CELL_W-1:0]  sweep_wdata;

	logic               sw_last;
	logic               sw_desc;
	logic [ROW_W-1:0]   src_row;
	logic [COL_W-1:0]   src_col;
	logic [ROW_W-1:0]   tw_row;
	logic [COL_W-1:0]   tw_col;
	logic               tw_scroll;
	logic               accept;
	logic               out_load;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_out_q;
	logic [ROW_W-1:0]   cur_row_out_q;
	logic [COL_W-1:0]   cur_col_out_q;
	logic [DIRTY_W-1:0] dirty_out_q;

	assign in_stall          = (state_q != ST_IDLE);
	assign accept            = in_valid && !in_stall;
	assign out_valid         = out_valid_q;
	assign char_out          = char_out_q;
	assign cursor_row_out    = cur_row_out_q;
	assign cursor_column_out = cur_col_out_q;
	assign dirty_out         = dirty_out_q;

	always_comb begin
		unique case (sw_mode_s1)
			SW_INV_SET: sweep_wdata = {1'b1, rd_data_s1[6:0]};
			SW_INV_CLR: sweep_wdata = {1'b0, rd_data_s1[6:0]};
			default:    sweep_wdata = rd_data_s1;
		endcase
		if (fill_s1) begin
			sweep_wdata = '0;
		end
	end

	always_comb begin
		sw_desc = (sw_mode_q == SW_DOWN) || (sw_mode_q == SW_RIGHT);
		if (sw_desc) begin
			sw_last = (sw_row_q == '0) && (sw_col_q == '0);
		end else if (sw_mode_q == SW_INV_SET || sw_mode_q == SW_INV_CLR) begin
			sw_last = (sw_col_q == LAST_COL);
		end else begin
			sw_last = (sw_row_q == LAST_ROW) && (sw_col_q == LAST_COL);
		end
	end

	always_comb begin
		state_d      = state_q;
		cursor_row_d = cursor_row_q;
		cursor_col_d = cursor_col_q;
		dirty_d      = dirty_q;
		sw_mode_d    = sw_mode_q;
		sw_row_d     = sw_row_q;
		sw_col_d     = sw_col_q;
		init_d       = init_q;
		post_put_d   = post_put_q;
		put_addr_d   = put_addr_q;
		put_data_d   = put_data_q;
		get_hit_d    = get_hit_q;
		wr_en_d      = 1'b0;
		wr_addr_d    = addr_of(sw_row_q, sw_col_q);
		fill_d       = 1'b0;
		src_row      = sw_row_q;
		src_col      = sw_col_q;
		tw_row       = cursor_row_q;
		tw_col       = cursor_col_q;
		tw_scroll    = 1'b0;
		mem_re       = 1'b0;
		mem_raddr    = addr_of(row_q, col_q);
		mem_we       = wr_en_s1;
		mem_waddr    = wr_addr_s1;
		mem_wdata    = sweep_wdata;
		out_load     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end

			ST_EXEC: begin
				state_d    = ST_RESP;
				get_hit_d  = 1'b0;
				post_put_d = 1'b0;
				unique case (act_q)
					ACT_WRITE: begin
						if (char_q == NEWLINE) begin
							cursor_col_d = '0;
							if (cursor_row_q < ROWS_L) begin
								cursor_row_d = ROW_W'(cursor_row_q + 1'b1);
							end else begin
								dirty_d   = ALL_ROWS;
								sw_mode_d = SW_UP;
								sw_row_d  = '0;
								sw_col_d  = '0;
								state_d   = ST_SWEEP;
							end
						end else if (char_q >= CODE_BIAS) begin
							if (tw_col >= COLS_L) begin
								tw_col = '0;
								if (tw_row < ROWS_L) begin
									tw_row = ROW_W'(tw_row + 1'b1);
								end
							end
							if (tw_row >= ROWS_L) begin
								tw_scroll = 1'b1;
								tw_row    = LAST_ROW;
							end
							cursor_row_d = tw_row;
							cursor_col_d = COL_W'(tw_col + 1'b1);
							put_addr_d   = addr_of(tw_row, tw_col);
							put_data_d   = {inverse_q, 7'(char_q - CODE_BIAS)};
							dirty_d      = (tw_scroll ? ALL_ROWS : dirty_q)
								| (DIRTY_W'(1) << tw_row);
							if (tw_scroll) begin
								// scroll first, the character lands after the sweep
								post_put_d = 1'b1;
								sw_mode_d  = SW_UP;
								sw_row_d   = '0;
								sw_col_d   = '0;
								state_d    = ST_SWEEP;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = put_addr_d;
								mem_wdata = put_data_d;
							end
						end
					end
					ACT_PUT: begin
						if (row_q < ROWS_L && col_q < COLS_L) begin
							mem_we    = 1'b1;
							mem_waddr = addr_of(row_q, col_q);
							mem_wdata = {inverse_q, 7'(char_q - CODE_BIAS)};
							dirty_d   = dirty_q | (DIRTY_W'(1) << row_q);
						end
					end
					ACT_GET: begin
						get_hit_d = (row_q < ROWS_L) && (col_q < COLS_L);
						mem_re    = get_hit_d;
					end
					ACT_INVERT: begin
						if (row_q < ROWS_L) begin
							dirty_d   = dirty_q | (DIRTY_W'(1) << row_q);
							sw_mode_d = inv_flag_q ? SW_INV_SET : SW_INV_CLR;
							sw_row_d  = row_q;
							sw_col_d  = '0;
							state_d   = ST_SWEEP;
						end
					end
					ACT_SET_CURSOR: begin
						cursor_row_d = (row_q > ROWS_L) ? ROWS_L : row_q;
						cursor_col_d = (col_q > COLS_L) ? COLS_L : col_q;
						if (cursor_row_d == ROWS_L) begin
							cursor_col_d = '0;
						end
					end
					ACT_SCROLL: begin
						dirty_d = ALL_ROWS;
						state_d = ST_SWEEP;
						case (dir_q)
							DIR_UP: begin
								sw_mode_d = SW_UP;
								sw_row_d  = '0;
								sw_col_d  = '0;
							end
							DIR_DOWN: begin
								sw_mode_d = SW_DOWN;
								sw_row_d  = LAST_ROW;
								sw_col_d  = LAST_COL;
							end
							DIR_LEFT: begin
								sw_mode_d = SW_LEFT;
								sw_row_d  = '0;
								sw_col_d  = '0;
							end
							default: begin
								sw_mode_d = SW_RIGHT;
								sw_row_d  = LAST_ROW;
								sw_col_d  = LAST_COL;
							end
						endcase
					end
					ACT_CLEAR: begin
						dirty_d      = '0;
						cursor_row_d = '0;
						cursor_col_d = '0;
						sw_mode_d    = SW_ZERO;
						sw_row_d     = '0;
						sw_col_d     = '0;
						state_d      = ST_SWEEP;
					end
					ACT_MARK_DIRTY: begin
						dirty_d = ALL_ROWS;
					end
					default: begin
					end
				endcase
			end

			ST_SWEEP: begin
				// read the source cell now, write the target in the next cycle
				unique case (sw_mode_q)
					SW_UP: begin
						src_row = ROW_W'(sw_row_q + 1'b1);
						fill_d  = (sw_row_q == LAST_ROW);
					end
					SW_DOWN: begin
						src_row = ROW_W'(sw_row_q - 1'b1);
						fill_d  = (sw_row_q == '0);
					end
					SW_LEFT: begin
						src_col = COL_W'(sw_col_q + 1'b1);
						fill_d  = (sw_col_q == LAST_COL);
					end
					SW_RIGHT: begin
						src_col = COL_W'(sw_col_q - 1'b1);
						fill_d  = (sw_col_q == '0);
					end
					SW_INV_SET, SW_INV_CLR: begin
						fill_d = 1'b0;
					end
					SW_ZERO: begin
						fill_d = 1'b1;
					end
					default: begin
						fill_d = 1'b1;
					end
				endcase
				mem_re    = !fill_d;
				mem_raddr = addr_of(src_row, src_col);
				wr_en_d   = 1'b1;
				wr_addr_d = addr_of(sw_row_q, sw_col_q);
				if (sw_last) begin
					state_d = ST_DRAIN;
				end else if (sw_desc) begin
					if (sw_col_q == '0) begin
						sw_col_d = LAST_COL;
						sw_row_d = ROW_W'(sw_row_q - 1'b1);
					end else begin
						sw_col_d = COL_W'(sw_col_q - 1'b1);
					end
				end else begin
					if (sw_col_q == LAST_COL) begin
						sw_col_d = '0;
						sw_row_d = ROW_W'(sw_row_q + 1'b1);
					end else begin
						sw_col_d = COL_W'(sw_col_q + 1'b1);
					end
				end
			end

			ST_DRAIN: begin
				init_d = 1'b0;
				if (init_q) begin
					state_d = ST_IDLE;
				end else if (post_put_q) begin
					state_d = ST_PUTW;
				end else begin
					state_d = ST_RESP;
				end
			end

			ST_PUTW: begin
				mem_we     = 1'b1;
				mem_waddr  = put_addr_q;
				mem_wdata  = put_data_q;
				post_put_d = 1'b0;
				state_d    = ST_RESP;
			end

			ST_RESP: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (act_q == ACT_TAKE_DIRTY) begin
						dirty_d = '0;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_q    <= 1'b0;
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			dirty_q      <= '0;
			sw_mode_q    <= SW_ZERO;
			sw_row_q     <= '0;
			sw_col_q     <= '0;
			init_q       <= 1'b1;
			post_put_q   <= 1'b0;
			get_hit_q    <= 1'b0;
			wr_en_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				inverse_q <= text_inverse;
			end
			cursor_row_q <= cursor_row_d;
			cursor_col_q <= cursor_col_d;
			dirty_q      <= dirty_d;
			sw_mode_q    <= sw_mode_d;
			sw_row_q     <= sw_row_d;
			sw_col_q     <= sw_col_d;
			init_q       <= init_d;
			post_put_q   <= post_put_d;
			get_hit_q    <= get_hit_d;
			wr_en_s1     <= wr_en_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= action;
			row_q      <= row;
			col_q      <= column;
			char_q     <= char_code;
			inv_flag_q <= invert_flag;
			dir_q      <= direction;
		end
		put_addr_q <= put_addr_d;
		put_data_q <= put_data_d;
		wr_addr_s1 <= wr_addr_d;
		fill_s1    <= fill_d;
		sw_mode_s1 <= sw_mode_q;
		if (out_load) begin
			char_out_q    <= get_hit_q ? CHAR_W'({1'b0, rd_data_s1[6:0]}) + CODE_BIAS : '0;
			cur_row_out_q <= cursor_row_q;
			cur_col_out_q <= cursor_col_q;
			dirty_out_q   <= dirty_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= cell_mem_q[mem_raddr];
		end
	end

endmodule

// ===== rtl/ttcb_checker.sv =====
// Port-level checks of the text terminal cell buffer and their bind
`timescale 1ns / 1ps
`include "text_terminal_cell_buffer_macros.svh"
module ttcb_checker #(
	parameter int ROWS    = ttcb_pkg::DEF_ROWS,
	parameter int COLUMNS = ttcb_pkg::DEF_COLUMNS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [ttcb_pkg::CHAR_W-1:0]   char_out,
	input logic [ttcb_pkg::ROW_W-1:0]    cursor_row_out,
	input logic [ttcb_pkg::COL_W-1:0]    cursor_column_out,
	input logic [ttcb_pkg::DIRTY_W-1:0]  dirty_out
);
	import ttcb_pkg::*;

	localparam logic [ROW_W-1:0]   ROWS_L   = ROW_W'(ROWS);
	localparam logic [COL_W-1:0]   COLS_L   = COL_W'(COLUMNS);
	localparam logic [DIRTY_W-1:0] ALL_ROWS = DIRTY_W'((1 << ROWS) - 1);
	// highest code a get can return
	localparam logic [CHAR_W-1:0]  CHAR_TOP = 8'h9F;

	logic [CHAR_W+ROW_W+COL_W+DIRTY_W-1:0] out_payload;
	logic                                  dirty_ok;
	logic                                  char_ok;
	logic                                  cursor_ok;

	assign out_payload = {char_out, cursor_row_out, cursor_column_out, dirty_out};
	assign dirty_ok    = ((dirty_out & ~ALL_ROWS) == '0);
	assign char_ok     = (char_out == '0) || (char_out >= CODE_BIAS && char_out <= CHAR_TOP);
	assign cursor_ok   = (cursor_row_out <= ROWS_L) && (cursor_column_out <= COLS_L);

	// a stalled result beat stays up
	`TTCB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// a stalled result beat keeps its payload
	`TTCB_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_payload))

	// one item at a time: the cycle after an input beat the block is busy
	`TTCB_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)

	// a cursor below the last row always sits in column zero
	`TTCB_ASSERT_NOW(a_cursor_bottom, out_valid && cursor_row_out == ROWS_L, cursor_column_out == '0)

	// only rows that exist are marked, read codes are zero or 20h..9Fh, cursor at most one past the last row and column
	`TTCB_ASSERT_NOW(a_report_range, out_valid, dirty_ok && char_ok && cursor_ok)

endmodule

bind text_terminal_cell_buffer ttcb_checker #(
	.ROWS    (ROWS),
	.COLUMNS (COLUMNS)
) u_ttcb_checker (.*);

// ===== sim/ttcb_screen_checker.sv =====
// Checker for the text terminal cell buffer: screen predictor and result comparison
`timescale 1ns / 1ps
module ttcb_screen_checker
	import ttcb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic               text_inverse,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [ACT_W-1:0]   action,
	input  logic [ROW_W-1:0]   row,
	input  logic [COL_W-1:0]   column,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic               invert_flag,
	input  logic [DIR_W-1:0]   direction,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [CHAR_W-1:0]  char_out,
	input  logic [ROW_W-1:0]   cursor_row_out,
	input  logic [COL_W-1:0]   cursor_column_out,
	input  logic [DIRTY_W-1:0] dirty_out,
	output int                 pending,
	output int                 fail_count,
	output int                 checked
);

	localparam int NROWS = DEF_ROWS;
	localparam int NCOLS = DEF_COLUMNS;
	localparam logic [DIRTY_W-1:0] ALL_ROWS = DIRTY_W'((1 << NROWS) - 1);

	typedef struct packed {
		logic [CHAR_W-1:0]  ch;
		logic [ROW_W-1:0]   crow;
		logic [COL_W-1:0]   ccol;
		logic [DIRTY_W-1:0] dirty;
	} screen_result_t;

	logic [CELL_W-1:0]  cells [NROWS][NCOLS];
	logic [DIRTY_W-1:0] dirty_mask;
	logic [ROW_W-1:0]   cur_row;
	logic [COL_W-1:0]   cur_col;
	logic               inverse_mode;
	screen_result_t     screen_results_q[$];

	initial begin
		fail_count = 0;
		checked    = 0;
		pending    = 0;
	end

	task automatic report(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic blank_screen();
		for (int r = 0; r < NROWS; r++)
			for (int c = 0; c < NCOLS; c++)
				cells[r][c] = '0;
	endtask

	task automatic shift_screen(input logic [DIR_W-1:0] dir);
		case (dir)
			DIR_UP: begin
				for (int r = 0; r < NROWS - 1; r++)
					for (int c = 0; c < NCOLS; c++)
						cells[r][c] = cells[r+1][c];
				for (int c = 0; c < NCOLS; c++)
					cells[NROWS-1][c] = '0;
			end
			DIR_DOWN: begin
				for (int r = NROWS - 1; r > 0; r--)
					for (int c = 0; c < NCOLS; c++)
						cells[r][c] = cells[r-1][c];
				for (int c = 0; c < NCOLS; c++)
					cells[0][c] = '0;
			end
			DIR_LEFT: begin
				for (int r = 0; r < NROWS; r++) begin
					for (int c = 0; c < NCOLS - 1; c++)
						cells[r][c] = cells[r][c+1];
					cells[r][NCOLS-1] = '0;
				end
			end
			default: begin
				for (int r = 0; r < NROWS; r++) begin
					for (int c = NCOLS - 1; c > 0; c--)
						cells[r][c] = cells[r][c-1];
					cells[r][0] = '0;
				end
			end
		endcase
		dirty_mask = ALL_ROWS;
	endtask

	task automatic store_cell(input int r, input int c, input logic [CHAR_W-1:0] ch);
		if (r < NROWS && c < NCOLS) begin
			cells[r][c] = {inverse_mode, 7'(ch - CODE_BIAS)};
			dirty_mask[r] = 1'b1;
		end
	endtask

	task automatic term_write(input logic [CHAR_W-1:0] ch);
		if (ch == NEWLINE) begin
			cur_col = '0;
			if (cur_row < NROWS)
				cur_row = cur_row + 1'b1;
			else
				shift_screen(DIR_UP);
		end else if (ch >= CODE_BIAS) begin
			// wrap off the line end, then scroll if that ran off the bottom
			if (cur_col >= NCOLS) begin
				cur_col = '0;
				if (cur_row < NROWS)
					cur_row = cur_row + 1'b1;
			end
			if (cur_row >= NROWS) begin
				shift_screen(DIR_UP);
				cur_row = ROW_W'(NROWS - 1);
			end
			store_cell(cur_row, cur_col, ch);
			cur_col = cur_col + 1'b1;
		end
	endtask

	task automatic predict_screen_step(output screen_result_t res);
		logic [CHAR_W-1:0] got_char;
		got_char = '0;
		case (action)
			ACT_WRITE: term_write(char_code);
			ACT_PUT:   store_cell(row, column, char_code);
			ACT_GET: begin
				if (row < NROWS && column < NCOLS)
					got_char = {1'b0, cells[row][column][6:0]} + CODE_BIAS;
			end
			ACT_INVERT: begin
				if (row < NROWS) begin
					for (int c = 0; c < NCOLS; c++)
						cells[row][c][7] = invert_flag;
					dirty_mask[row] = 1'b1;
				end
			end
			ACT_SET_CURSOR: begin
				cur_row = (row > NROWS) ? ROW_W'(NROWS) : row;
				cur_col = (column > NCOLS) ? COL_W'(NCOLS) : column;
				if (cur_row == NROWS)
					cur_col = '0;
			end
			ACT_SCROLL: shift_screen(direction);
			ACT_CLEAR: begin
				blank_screen();
				dirty_mask = '0;
				cur_row    = '0;
				cur_col    = '0;
			end
			ACT_MARK_DIRTY: dirty_mask = ALL_ROWS;
			default: ;
		endcase
		res.ch    = got_char;
		res.crow  = cur_row;
		res.ccol  = cur_col;
		res.dirty = dirty_mask & ALL_ROWS;
		// take dirty reports the mask before clearing it
		if (action == ACT_TAKE_DIRTY)
			dirty_mask = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		screen_result_t want;
		screen_result_t seen;
		if (!arst_n) begin
			blank_screen();
			dirty_mask   = '0;
			cur_row      = '0;
			cur_col      = '0;
			inverse_mode = 1'b0;
			screen_results_q.delete();
			pending <= 0;
		end else begin
			if (cfg_write_en)
				inverse_mode = text_inverse;
			// results first: a beat can never answer an item taken at the same edge
			if (out_valid && !out_stall) begin
				seen = {char_out, cursor_row_out, cursor_column_out, dirty_out};
				if (screen_results_q.size() == 0) begin
					report($sformatf("result beat with nothing expected (%h)", seen));
				end else begin
					want = screen_results_q.pop_front();
					checked++;
					if (seen.ch !== want.ch)
						report($sformatf("char_out expected %02h got %02h", want.ch, seen.ch));
					if (seen.crow !== want.crow)
						report($sformatf("cursor_row_out expected %0d got %0d",
							want.crow, seen.crow));
					if (seen.ccol !== want.ccol)
						report($sformatf("cursor_column_out expected %0d got %0d",
							want.ccol, seen.ccol));
					if (seen.dirty !== want.dirty)
						report($sformatf("dirty_out expected %04h got %04h",
							want.dirty, seen.dirty));
				end
			end
			if (in_valid && !in_stall) begin
				predict_screen_step(want);
				screen_results_q.push_back(want);
			end
			pending <= screen_results_q.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the text terminal cell buffer: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_top;
	import ttcb_pkg::*;

	typedef struct {
		logic [ACT_W-1:0]  act;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [CHAR_W-1:0] ch;
		logic              inv;
		logic [DIR_W-1:0]  dir;
	} screen_cmd_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_write_en = 1'b0;
	logic               text_inverse = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [ACT_W-1:0]   action       = '0;
	logic [ROW_W-1:0]   row          = '0;
	logic [COL_W-1:0]   column       = '0;
	logic [CHAR_W-1:0]  char_code    = '0;
	logic               invert_flag  = 1'b0;
	logic [DIR_W-1:0]   direction    = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic [CHAR_W-1:0]  char_out;
	logic [ROW_W-1:0]   cursor_row_out;
	logic [COL_W-1:0]   cursor_column_out;
	logic [DIRTY_W-1:0] dirty_out;

	int pending;
	int fail_count;
	int checked;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int beats_sent  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_terminal_cell_buffer u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .text_inverse(text_inverse),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .row(row), .column(column), .char_code(char_code),
		.invert_flag(invert_flag), .direction(direction),
		.out_valid(out_valid), .out_stall(out_stall),
		.char_out(char_out), .cursor_row_out(cursor_row_out),
		.cursor_column_out(cursor_column_out), .dirty_out(dirty_out)
	);

	ttcb_screen_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .text_inverse(text_inverse),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .row(row), .column(column), .char_code(char_code),
		.invert_flag(invert_flag), .direction(direction),
		.out_valid(out_valid), .out_stall(out_stall),
		.char_out(char_out), .cursor_row_out(cursor_row_out),
		.cursor_column_out(cursor_column_out), .dirty_out(dirty_out),
		.pending(pending), .fail_count(fail_count), .checked(checked)
	);

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

	function automatic screen_cmd_t mk(input logic [ACT_W-1:0] act, input int r, input int c,
		input int ch, input logic inv, input logic [DIR_W-1:0] dir);
		screen_cmd_t cmd;
		cmd.act = act;
		cmd.row = ROW_W'(r);
		cmd.col = COL_W'(c);
		cmd.ch  = CHAR_W'(ch);
		cmd.inv = inv;
		cmd.dir = dir;
		return cmd;
	endfunction

	// mostly well-formed terminal traffic; unused fields always carry noise
	function automatic screen_cmd_t random_cmd();
		screen_cmd_t cmd;
		int pick;
		cmd.act = ACT_READ_CURSOR;
		cmd.row = ROW_W'($urandom);
		cmd.col = COL_W'($urandom);
		cmd.ch  = CHAR_W'($urandom);
		cmd.inv = 1'($urandom);
		cmd.dir = DIR_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			cmd.act = ACT_WRITE;
			if ($urandom_range(0, 9) == 0)
				cmd.ch = NEWLINE;
			else if ($urandom_range(0, 9) != 0)
				cmd.ch = CHAR_W'($urandom_range(8'h20, 8'h7e));
		end else if (pick < 55 || pick < 70) begin
			cmd.act = (pick < 55) ? ACT_PUT : ACT_GET;
			if ($urandom_range(0, 9) != 0) begin
				cmd.row = ROW_W'($urandom_range(0, DEF_ROWS - 1));
				cmd.col = COL_W'($urandom_range(0, DEF_COLUMNS - 1));
			end
		end else if (pick < 75) begin
			cmd.act = ACT_INVERT;
		end else if (pick < 83) begin
			cmd.act = ACT_SET_CURSOR;
			// favor the bottom rows so wraps and scroll-ups happen often
			if ($urandom_range(0, 1) == 0)
				cmd.row = ROW_W'($urandom_range(DEF_ROWS - 2, DEF_ROWS));
		end else if (pick < 87) begin
			cmd.act = ACT_READ_CURSOR;
		end else if (pick < 89) begin
			cmd.act = ACT_SCROLL;
		end else if (pick < 90) begin
			cmd.act = ACT_CLEAR;
		end else if (pick < 94) begin
			cmd.act = ACT_TAKE_DIRTY;
		end else if (pick < 96) begin
			cmd.act = ACT_MARK_DIRTY;
		end else begin
			cmd.act = ACT_W'($urandom_range(10, 15));
		end
		return cmd;
	endfunction

	task automatic send_beat(input screen_cmd_t cmd);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		action      <= cmd.act;
		row         <= cmd.row;
		column      <= cmd.col;
		char_code   <= cmd.ch;
		invert_flag <= cmd.inv;
		direction   <= cmd.dir;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	// sender goes quiet until every outstanding result has been taken
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_inverse(input logic value);
		cfg_write_en <= 1'b1;
		text_inverse <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic run_phase(input int n, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				wait_drain();
			send_beat(random_cmd());
		end
		wait_drain();
	endtask

	initial begin
		int guard;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_inverse(1'b1);

		// directed: field extremes, every action and the corner cases
		send_beat(mk(ACT_PUT, 0, 0, 8'h00, 0, DIR_UP));           // control byte via put
		send_beat(mk(ACT_PUT, 14, 24, 8'hff, 0, DIR_UP));         // last cell, top byte
		send_beat(mk(ACT_PUT, 15, 0, 8'h41, 1, DIR_UP));          // row out of range
		send_beat(mk(ACT_PUT, 0, 31, 8'h41, 1, DIR_UP));          // column out of range
		send_beat(mk(ACT_GET, 14, 24, 8'h00, 0, DIR_UP));
		send_beat(mk(ACT_GET, 15, 31, 8'hff, 1, DIR_RIGHT));      // out of range read
		send_beat(mk(ACT_GET, 0, 25, 8'h00, 0, DIR_UP));
		send_beat(mk(ACT_INVERT, 14, 0, 8'h00, 1, DIR_UP));
		send_beat(mk(ACT_INVERT, 15, 0, 8'h00, 1, DIR_UP));       // ignored row
		send_beat(mk(ACT_INVERT, 14, 0, 8'h00, 0, DIR_UP));
		send_beat(mk(ACT_SET_CURSOR, 15, 31, 8'h00, 0, DIR_UP));  // clamps to bottom, col 0
		send_beat(mk(ACT_WRITE, 0, 0, NEWLINE, 0, DIR_UP));       // newline below last row
		send_beat(mk(ACT_SET_CURSOR, 14, 31, 8'h00, 0, DIR_UP));  // one past line end
		send_beat(mk(ACT_WRITE, 0, 0, 8'h7f, 0, DIR_UP));         // wrap then scroll up
		send_beat(mk(ACT_WRITE, 0, 0, 8'h1f, 0, DIR_UP));         // ignored control byte
		send_beat(mk(ACT_WRITE, 0, 0, 8'h80, 0, DIR_UP));
		send_beat(mk(ACT_SCROLL, 0, 0, 8'h00, 0, DIR_DOWN));
		send_beat(mk(ACT_SCROLL, 0, 0, 8'h00, 0, DIR_LEFT));
		send_beat(mk(ACT_SCROLL, 0, 0, 8'h00, 0, DIR_RIGHT));
		send_beat(mk(ACT_SCROLL, 0, 0, 8'h00, 0, DIR_UP));
		send_beat(mk(ACT_TAKE_DIRTY, 0, 0, 8'h00, 0, DIR_UP));
		send_beat(mk(ACT_READ_CURSOR, 0, 0, 8'h00, 0, DIR_UP));
		send_beat(mk(ACT_MARK_DIRTY, 0, 0, 8'h00, 0, DIR_UP));
		send_beat(mk(4'd15, 15, 31, 8'hff, 1, DIR_RIGHT));       // unused action code
		send_beat(mk(ACT_CLEAR, 0, 0, 8'h00, 0, DIR_UP));
		wait_drain();

		write_inverse(1'b0);
		run_phase(400, 16, 85);
		write_inverse(1'b1);
		run_phase(400, 85, 16);
		write_inverse(1'b0);
		run_phase(400, 0, 0);
		write_inverse(1'b1);
		run_phase(400, 0, 0);

		guard = 0;
		while (pending != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);

		$display("Sent %0d beats over every action, all scroll directions and both inverse",
			beats_sent);
		$display("settings under three idle mixes; %0d results compared.", checked);
		if (pending != 0)
			$display("%0d expected results never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#(30_000_000);
		$display("Timeout with %0d results outstanding", pending);
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ttcb_pkg.sv
rtl/text_terminal_cell_buffer.sv
rtl/ttcb_checker.sv
sim/ttcb_screen_checker.sv
sim/tb_top.sv
